// ===== src/bstg_pkg.sv =====
// ----------------------------------------------------------------------------
// bstg_pkg
// Shared constants, result type and reload table for the stepped tone block.
// ----------------------------------------------------------------------------
package bstg_pkg;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned TICK_W     = 8;

  localparam logic [LEVEL_W-1:0]    LEVEL_MIN      = 4'd1;
  localparam logic [LEVEL_W-1:0]    LEVEL_MAX      = 4'd9;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd230;
  localparam logic [TICK_W-1:0]     TICK_TOP       = 8'hFF;

  // one result transaction
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               wave;
    logic               led;
    logic               level_changed;
  } result_t;

  // timer reload value per level, out-of-range levels use the top entry
  function automatic logic [TICK_W-1:0] reload_for_level(input logic [LEVEL_W-1:0] lvl);
    logic [TICK_W-1:0] val;
    case (lvl)
      4'd1:    val = 8'd14;
      4'd2:    val = 8'd141;
      4'd3:    val = 8'd184;
      4'd4:    val = 8'd207;
      4'd5:    val = 8'd222;
      4'd6:    val = 8'd233;
      4'd7:    val = 8'd240;
      4'd8:    val = 8'd247;
      default: val = 8'd250;
    endcase
    return val;
  endfunction

endpackage

// ===== src/bstg_core.sv =====
// ----------------------------------------------------------------------------
// bstg_core
// Debounce, ping-pong level stepping, tone timer and LED toggle state.
// ----------------------------------------------------------------------------
module bstg_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr,
  input  logic [bstg_pkg::DEBOUNCE_W-1:0]    cfg_debounce_ticks,
  input  logic                               step_en,
  input  logic                               button_held,
  input  logic                               led_toggle_request,
  output bstg_pkg::result_t                  result
);

  logic [bstg_pkg::DEBOUNCE_W-1:0] debounce_ticks_r;
  logic [bstg_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic                            down_r, down_nxt;
  logic [bstg_pkg::DEBOUNCE_W-1:0] left_r, left_nxt;
  logic                            wait_r, wait_nxt;
  logic [bstg_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic                            wave_r, wave_nxt;
  logic                            led_r, led_nxt;
  logic                            changed;

  // next state for one tick
  always_comb begin
    level_nxt = level_r;
    down_nxt  = down_r;
    left_nxt  = left_r;
    wait_nxt  = wait_r;
    changed   = 1'b0;

    // button debounce and level step
    if (button_held) begin
      if (!wait_r) begin
        if (left_r != '0) begin
          left_nxt = left_r - 1'b1;
        end
        if (left_nxt == '0) begin
          changed  = 1'b1;
          wait_nxt = 1'b1;
          if (down_r) begin
            if (level_r > bstg_pkg::LEVEL_MIN) begin
              level_nxt = level_r - 1'b1;
            end
            if (level_nxt <= bstg_pkg::LEVEL_MIN) begin
              down_nxt = 1'b0;
            end
          end else begin
            if (level_r < bstg_pkg::LEVEL_MAX) begin
              level_nxt = level_r + 1'b1;
            end
            if (level_nxt >= bstg_pkg::LEVEL_MAX) begin
              down_nxt = 1'b1;
            end
          end
        end
      end
    end else begin
      left_nxt = debounce_ticks_r;
      wait_nxt = 1'b0;
    end

    // tone timer, reload uses the level after stepping
    if (tick_r == bstg_pkg::TICK_TOP) begin
      tick_nxt = bstg_pkg::reload_for_level(level_nxt);
      wave_nxt = !wave_r;
    end else begin
      tick_nxt = tick_r + 1'b1;
      wave_nxt = wave_r;
    end

    led_nxt = led_toggle_request ? !led_r : led_r;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= bstg_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr) begin
      debounce_ticks_r <= cfg_debounce_ticks;
    end
  end

  // state advances once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= bstg_pkg::LEVEL_MIN;
      down_r  <= 1'b0;
      left_r  <= bstg_pkg::DEBOUNCE_RESET;
      wait_r  <= 1'b0;
      tick_r  <= '0;
      wave_r  <= 1'b0;
      led_r   <= 1'b0;
    end else if (step_en) begin
      level_r <= level_nxt;
      down_r  <= down_nxt;
      left_r  <= left_nxt;
      wait_r  <= wait_nxt;
      tick_r  <= tick_nxt;
      wave_r  <= wave_nxt;
      led_r   <= led_nxt;
    end
  end

  assign result.level         = level_nxt;
  assign result.wave          = wave_nxt;
  assign result.led           = led_nxt;
  assign result.level_changed = changed;

endmodule

// ===== src/button_stepped_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// button_stepped_tone_generator_unit
// Debounced ping-pong level selector driving a table-reloaded tone timer.
// ----------------------------------------------------------------------------
// Each input transaction is one tick and yields exactly one result transaction.
// A tick is taken every clock cycle unless in_stall is high: the state update
// is a single pass of logic from the state registers, and the result lands in
// an output register backed by one skid entry, so input keeps flowing after
// the output stalls and in_stall rises only once the skid entry holds a result.
// The user must write the debounce threshold through the cfg port (always
// ready) only while the block is idle, which the block does not enforce; a
// new value takes effect at the next button release.
module button_stepped_tone_generator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bstg_pkg::DEBOUNCE_W-1:0] cfg_debounce_ticks,
  // input ticks
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_button_held,
  input  logic                            in_led_toggle_request,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bstg_pkg::LEVEL_W-1:0]    out_level,
  output logic                            out_wave,
  output logic                            out_led,
  output logic                            out_level_changed
);

  bstg_pkg::result_t result;
  bstg_pkg::result_t out_r, out_nxt;
  bstg_pkg::result_t skid_r, skid_nxt;
  logic              out_v_r, out_v_nxt;
  logic              skid_v_r, skid_v_nxt;
  logic              in_acc;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_v_r;
  assign in_acc    = in_valid && !skid_v_r;
  assign out_free  = !out_v_r || !out_stall;

  bstg_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_debounce_ticks (cfg_debounce_ticks),
    .step_en            (in_acc),
    .button_held        (in_button_held),
    .led_toggle_request (in_led_toggle_request),
    .result             (result)
  );

  // output register with one skid entry
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (out_free) begin
      out_v_nxt  = skid_v_r || in_acc;
      out_nxt    = skid_v_r ? skid_r : result;
      skid_v_nxt = 1'b0;
    end else if (in_acc) begin
      skid_nxt   = result;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_v_r;
  assign out_level         = out_r.level;
  assign out_wave          = out_r.wave;
  assign out_led           = out_r.led;
  assign out_level_changed = out_r.level_changed;

endmodule
